// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, clocked on clk and disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)

`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

// ----- sv/bcoef_pkg.sv -----
// ----------------------------------------------------------------------------
// bcoef_pkg
// Widths, constants and cell control type for the binomial coefficient block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcoef_pkg;

	localparam int IN_W    = 8;
	localparam int N_W     = 6;
	localparam int D_W     = 5;
	localparam int R_W     = 64;
	localparam int COEF_W  = 59;
	localparam int CNT_W   = 6;
	localparam int MAX_N_DEF = 62;

	typedef struct packed {
		logic en;
		logic first;
	} cell_ctl_t;

endpackage

// ----- sv/bcoef_if.sv -----
// ----------------------------------------------------------------------------
// bcoef_in_if / bcoef_out_if
// Valid/ready channels for index words and coefficient words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bcoef_in_if import bcoef_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [IN_W-1:0] n_value;
	logic [IN_W-1:0] k_value;

	modport source (output valid, output n_value, output k_value, input ready);
	modport sink (input valid, input n_value, input k_value, output ready);
endinterface

interface bcoef_out_if import bcoef_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [COEF_W-1:0] coefficient;
	logic              out_of_range;

	modport source (output valid, output coefficient, output out_of_range, input ready);
	modport sink (input valid, input coefficient, input out_of_range, output ready);
endinterface

// ----- sv/binomial_coefficient_int_top.sv -----
// ----------------------------------------------------------------------------
// binomial_coefficient_int_top
// Exact binomial coefficient C(n,k) for n up to MAX_N.
//
// req carries one word of n_value and k_value; rsp returns one word of
// coefficient and out_of_range per request, in order.
// n above MAX_N returns 0 with out_of_range set. k above n returns 0;
// k of 0 or k equal to n returns 1. These go straight to ST_FIN.
// Otherwise k is folded to min(k, n-k) and the block runs k rounds, each
// a bit-serial multiply by the running top value and a bit-serial exact
// divide by the round number, all on one 64-bit shift register, before
// the result goes through ST_FIN to the output register.
// One request is processed at a time; req.ready is high only while idle.
// The result sits in an output register: the next request is accepted
// while it waits, and a finished result holds until rsp.ready frees it.
// Reset clears all control state and drops any pending result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module binomial_coefficient_int_top import bcoef_pkg::*; #(
	parameter int MAX_N = MAX_N_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	bcoef_in_if.sink    req,
	bcoef_out_if.source rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(R_W - 1);

	state_t            state_q;
	logic [R_W-1:0]    r_q;
	logic [N_W-1:0]    top_q;
	logic [D_W-1:0]    d_q;
	logic [D_W-1:0]    kk_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              oor_q;
	logic              ovalid_q;
	logic [COEF_W-1:0] coef_q;
	logic              oor_out_q;

	logic              accept;
	logic              rsp_free;
	logic [N_W-1:0]    n_in;
	logic [N_W-1:0]    k_in;
	logic [N_W-1:0]    nmk;
	logic [N_W-1:0]    kmin;
	cell_ctl_t         mul_ctl;
	cell_ctl_t         div_ctl;
	logic              mul_bit;
	logic              q_bit;

	assign req.ready       = (state_q == ST_IDLE);
	assign accept          = req.valid && req.ready;
	assign rsp_free        = !ovalid_q || rsp.ready;
	assign rsp.valid       = ovalid_q;
	assign rsp.coefficient = coef_q;
	assign rsp.out_of_range = oor_out_q;

	assign n_in = req.n_value[N_W-1:0];
	assign k_in = req.k_value[N_W-1:0];
	assign nmk  = n_in - k_in;
	assign kmin = (k_in > nmk) ? nmk : k_in;

	assign mul_ctl.en    = (state_q == ST_MUL);
	assign mul_ctl.first = (cnt_q == '0);
	assign div_ctl.en    = (state_q == ST_DIV);
	assign div_ctl.first = (cnt_q == '0);

	bcoef_mul_cell u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mul_ctl),
		.factor  (top_q),
		.bit_in  (r_q[0]),
		.bit_out (mul_bit)
	);

	bcoef_div_cell u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (div_ctl),
		.divisor (d_q),
		.bit_in  (r_q[R_W-1]),
		.q_bit   (q_bit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			ovalid_q  <= 1'b0;
			oor_q     <= 1'b0;
			r_q       <= '0;
			top_q     <= '0;
			d_q       <= '0;
			kk_q      <= '0;
			coef_q    <= '0;
			oor_out_q <= 1'b0;
		end else begin
			if (ovalid_q && rsp.ready && state_q != ST_FIN) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						oor_q <= 1'b0;
						if (req.n_value > IN_W'(MAX_N)) begin
							r_q     <= '0;
							oor_q   <= 1'b1;
							state_q <= ST_FIN;
						end else if (req.k_value > req.n_value) begin
							r_q     <= '0;
							state_q <= ST_FIN;
						end else if (k_in == '0 || k_in == n_in) begin
							r_q     <= R_W'(1);
							state_q <= ST_FIN;
						end else begin
							r_q     <= R_W'(1);
							top_q   <= n_in;
							d_q     <= D_W'(1);
							kk_q    <= kmin[D_W-1:0];
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					r_q   <= {mul_bit, r_q[R_W-1:1]};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					r_q   <= {r_q[R_W-2:0], q_bit};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						top_q <= top_q - 1'b1;
						d_q   <= d_q + 1'b1;
						state_q <= (d_q == kk_q) ? ST_FIN : ST_MUL;
					end
				end
				ST_FIN: begin
					if (rsp_free) begin
						coef_q    <= r_q[COEF_W-1:0];
						oor_out_q <= oor_q;
						ovalid_q  <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_CLK(a_round_in_range, (state_q == ST_MUL || state_q == ST_DIV) |-> (d_q != '0 && d_q <= kk_q), "round number outside 1..k")
	`ASSERT_CLK(a_oor_zero, (rsp.valid && rsp.out_of_range) |-> (rsp.coefficient == '0), "out-of-range word with nonzero coefficient")
	`ASSERT_CLK(a_round_advance, (state_q == ST_DIV && cnt_q == CNT_LAST) |=> (d_q == $past(d_q) + 1'b1 && top_q == $past(top_q) - 1'b1), "round counters did not advance")
	`ASSERT_NEVER(a_overwrite, state_q == ST_FIN && rsp_free && ovalid_q && !rsp.ready, "pending result overwritten")

endmodule

// ----- sv/bcoef_mul_cell.sv -----
// ----------------------------------------------------------------------------
// bcoef_mul_cell
// Bit-serial multiply by a small factor, LSB first, with a narrow carry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcoef_mul_cell import bcoef_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  cell_ctl_t      ctl,
	input  logic [N_W-1:0] factor,
	input  logic           bit_in,
	output logic           bit_out
);

	logic [N_W-1:0] carry_q;
	logic [N_W-1:0] carry_in;
	logic [N_W:0]   sum;

	assign carry_in = ctl.first ? '0 : carry_q;
	assign sum      = (bit_in ? {1'b0, factor} : '0) + {1'b0, carry_in};
	assign bit_out  = sum[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else if (ctl.en) begin
			carry_q <= sum[N_W:1];
		end
	end

endmodule

// ----- sv/bcoef_div_cell.sv -----
// ----------------------------------------------------------------------------
// bcoef_div_cell
// Bit-serial restoring divide by a small divisor, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcoef_div_cell import bcoef_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  cell_ctl_t      ctl,
	input  logic [D_W-1:0] divisor,
	input  logic           bit_in,
	output logic           q_bit
);

	logic [D_W-1:0] rem_q;
	logic [D_W-1:0] rem_in;
	logic [D_W:0]   trial;
	logic [D_W:0]   diff;

	assign rem_in = ctl.first ? '0 : rem_q;
	assign trial  = {rem_in, bit_in};
	assign q_bit  = (trial >= {1'b0, divisor});
	assign diff   = q_bit ? (trial - {1'b0, divisor}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (ctl.en) begin
			rem_q <= diff[D_W-1:0];
		end
	end

endmodule

// ----- dv/bcoef_result_check.sv -----
// ----------------------------------------------------------------------------
// bcoef_result_check
// Predicts and checks every coefficient word of the binomial coefficient block.
//
// Watches the request and response channels. Each accepted index word gets its
// exact C(n,k) worked out by the multiplicative loop on 64-bit values. Each
// accepted response word is compared field by field with the oldest prediction.
// Failures are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcoef_result_check import bcoef_pkg::*; #(
	parameter int MAX_N = MAX_N_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	bcoef_in_if   req,
	bcoef_out_if  rsp,
	output int    fail_count,
	output int    pending_count,
	output int    checked_count,
	output int    flagged_count,
	output int    beyond_n_count
);

	typedef struct packed {
		logic [IN_W-1:0]   n_value;
		logic [IN_W-1:0]   k_value;
		logic [COEF_W-1:0] coefficient;
		logic              out_of_range;
	} coef_word_t;

	coef_word_t pending_coefs [$];

	function automatic coef_word_t binomial_of(logic [IN_W-1:0] n, logic [IN_W-1:0] k);
		coef_word_t  w;
		logic [63:0] acc;
		logic [63:0] top;
		int unsigned fold;
		w.n_value      = n;
		w.k_value      = k;
		w.out_of_range = (n > MAX_N);
		w.coefficient  = '0;
		if (!w.out_of_range && k <= n) begin
			fold = 32'((k > n - k) ? n - k : k);
			acc  = 64'd1;
			top  = 64'(n);
			for (int unsigned d = 1; d <= fold; d++) begin
				acc = acc * top;
				top = top - 64'd1;
				acc = acc / 64'(d);
			end
			w.coefficient = acc[COEF_W-1:0];
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		coef_word_t want;
		if (!arst_n) begin
			fail_count     <= 0;
			pending_count  <= 0;
			checked_count  <= 0;
			flagged_count  <= 0;
			beyond_n_count <= 0;
			pending_coefs.delete();
		end else begin
			if (rsp.valid && rsp.ready) begin
				checked_count <= checked_count + 1;
				if (pending_coefs.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected coefficient word %0d/%0b", $realtime,
							rsp.coefficient, rsp.out_of_range);
					fail_count <= fail_count + 1;
				end else begin
					want = pending_coefs.pop_front();
					if (want.out_of_range)
						flagged_count <= flagged_count + 1;
					else if (want.k_value > want.n_value)
						beyond_n_count <= beyond_n_count + 1;
					if (rsp.coefficient !== want.coefficient ||
							rsp.out_of_range !== want.out_of_range) begin
						if (fail_count < 10)
							$display("%0t: C(%0d,%0d) expected %0d/%0b, got %0d/%0b",
								$realtime, want.n_value, want.k_value, want.coefficient,
								want.out_of_range, rsp.coefficient, rsp.out_of_range);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (req.valid && req.ready)
				pending_coefs.push_back(binomial_of(req.n_value, req.k_value));
			pending_count <= pending_coefs.size();
		end
	end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench top for the binomial coefficient block.
//
// Sends a directed set of index words (range edges, k of 0 and of n, k above
// n, n above the limit) and then a random mix weighted toward in-range words
// with small folded k. Both channels idle at random; once, the response side
// holds off for a long stretch so the block backs up. A watchdog ends a
// stalled run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top import bcoef_pkg::*;;

	localparam int RANDOM_WORDS   = 270;
	localparam int HOLD_CYCLES    = 700;
	localparam int DRAIN_CYCLES   = 4000;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic hold_rsp;
	int   sent_words;
	int   rsp_words;
	int   rsp_wait;
	int   idle_cycles;
	int   fail_count;
	int   pending_count;
	int   checked_count;
	int   flagged_count;
	int   beyond_n_count;

	bcoef_in_if  req_if ();
	bcoef_out_if rsp_if ();

	binomial_coefficient_int_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	bcoef_result_check u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req_if),
		.rsp            (rsp_if),
		.fail_count     (fail_count),
		.pending_count  (pending_count),
		.checked_count  (checked_count),
		.flagged_count  (flagged_count),
		.beyond_n_count (beyond_n_count)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	task automatic send_indices(input logic [IN_W-1:0] n, input logic [IN_W-1:0] k);
		int unsigned gap;
		gap = ((sent_words % 50) < 10) ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.n_value <= n;
		req_if.k_value <= k;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		sent_words++;
	endtask

	// drop ready for a drawn number of cycles after each accepted word, except within the first 12 of every 64 words
	always @(posedge clk or negedge arst_n) begin
		int g;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			rsp_wait     <= 0;
			rsp_words    <= 0;
		end else begin
			g = rsp_wait;
			if (rsp_if.valid && rsp_if.ready) begin
				rsp_words <= rsp_words + 1;
				g = ((rsp_words % 64) < 12) ? 0 : $urandom_range(0, 13);
			end
			if (g != 0) begin
				rsp_if.ready <= 1'b0;
				rsp_wait     <= g - 1;
			end else begin
				rsp_if.ready <= !hold_rsp;
				rsp_wait     <= 0;
			end
		end
	end

	initial begin
		hold_rsp = 1'b0;
		wait (checked_count >= 80);
		@(posedge clk);
		hold_rsp <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rsp <= 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		logic [15:0] directed [$];
		int unsigned n, k, sel, lim;
		directed = '{
			{8'd0, 8'd0}, {8'd0, 8'd1}, {8'd0, 8'd255}, {8'd1, 8'd0}, {8'd1, 8'd1},
			{8'd7, 8'd7}, {8'd5, 8'd2}, {8'd10, 8'd11}, {8'd40, 8'd20}, {8'd61, 8'd30},
			{8'd62, 8'd0}, {8'd62, 8'd1}, {8'd62, 8'd61}, {8'd62, 8'd62}, {8'd62, 8'd31},
			{8'd62, 8'd32}, {8'd62, 8'd63}, {8'd63, 8'd0}, {8'd63, 8'd63}, {8'd63, 8'd100},
			{8'd200, 8'd3}, {8'd255, 8'd0}, {8'd255, 8'd255}
		};
		sent_words     = 0;
		req_if.valid   <= 1'b0;
		req_if.n_value <= '0;
		req_if.k_value <= '0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_indices(directed[i][15:8], directed[i][7:0]);

		repeat (RANDOM_WORDS) begin
			sel = $urandom_range(0, 99);
			n   = $urandom_range(0, 62);
			if (sel < 20) begin
				n = $urandom_range(63, 255);
				k = $urandom_range(0, 255);
			end else if (sel < 35) begin
				k = $urandom_range(n + 1, 255);
			end else if (sel < 45) begin
				k = $urandom_range(0, 1) ? n : 0;
			end else if (sel < 93) begin
				lim = (n < 8) ? n : 8;
				k   = $urandom_range(0, lim);
				if ($urandom_range(0, 1))
					k = n - k;
			end else begin
				n = $urandom_range(50, 62);
				k = $urandom_range(0, n);
			end
			send_indices(n[IN_W-1:0], k[IN_W-1:0]);
		end
		req_if.valid <= 1'b0;

		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d index words, checked %0d coefficient words", sent_words,
			checked_count);
		$display("%0d flagged out of range, %0d with k above n, %0d mismatches",
			flagged_count, beyond_n_count, fail_count);
		if (fail_count == 0 && pending_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/bcoef_pkg.sv
sv/bcoef_if.sv
sv/bcoef_mul_cell.sv
sv/bcoef_div_cell.sv
sv/binomial_coefficient_int_top.sv
dv/bcoef_result_check.sv
dv/tb_top.sv
